>>> hdl/uet_pkg.sv
// ----------------------------------------------------------------------------
// uet_pkg
// Shared sizes, codes and interface structs of the unique edge table.
// ----------------------------------------------------------------------------
package uet_pkg;

    // table sizes
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 64;

    // field and address widths
    localparam int VTX_W   = 6;
    localparam int LINK_W  = $clog2(MAX_EDGES + 1);
    localparam int NODE_AW = $clog2(MAX_EDGES);
    localparam int HEAD_AW = $clog2(MAX_VERTICES);
    localparam int STAT_W  = 3;

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_LISTED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    typedef logic [LINK_W-1:0] t_link;

    // one pool node: high vertex and link to the next older node
    typedef struct packed {
        logic [VTX_W-1:0] hi;
        t_link            link;
    } t_node;

    // access requests from the controller to the store
    typedef struct packed {
        logic               head_rd;
        logic [HEAD_AW-1:0] head_raddr;
        logic               head_wr;
        logic [HEAD_AW-1:0] head_waddr;
        t_link              head_wdata;
        logic               node_rd;
        logic [NODE_AW-1:0] node_raddr;
        logic               node_wr;
        logic [NODE_AW-1:0] node_waddr;
        t_node              node_wdata;
    } t_store_req;

    // registered read data from the store
    typedef struct packed {
        t_link head_link;
        t_node node;
    } t_store_rsp;

endpackage

>>> hdl/unique_edge_table_unit.sv
// ----------------------------------------------------------------------------
// unique_edge_table_unit
// Undirected edge store without duplicates, with chained per-vertex lists.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. i_cmd selects an
//   insert of the edge (i_vertex_a, i_vertex_b) or a dump of all edges.
//   Results come out on o_status, o_edge_low, o_edge_high and o_last, each
//   for one cycle marked by o_valid; the receiver cannot stall them.
//   Insert: the vertices are ordered, the chain of the low vertex is walked
//   one node per cycle through the pool memory, and one result follows.
//   busy is high while the chain is walked; the result is on the ports in the
//   first cycle busy is low, and the next command can be taken at the edge
//   that ends that cycle.
//   Dump: heads are scanned in ascending vertex order, one memory read per
//   cycle (one per vertex head, one per listed node); results stream as
//   found, the final one flagged by o_last. An empty table gives one result.
//   The rate is set by the single read port of each memory: one head or
//   node lookup per cycle. busy stays high until the last result is issued.
//   Reset clears the state machine, the node count and the head valid bits;
//   the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module unique_edge_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [uet_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [uet_pkg::VTX_W-1:0]   i_vertex_b,
    output logic                        o_valid,
    output logic [uet_pkg::STAT_W-1:0]  o_status,
    output logic [uet_pkg::VTX_W-1:0]   o_edge_low,
    output logic [uet_pkg::VTX_W-1:0]   o_edge_high,
    output logic                        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_HEAD,
        S_INS_NODE,
        S_DUMP_HEAD,
        S_DUMP_NODE
    } t_state;

    t_state r_state, n_state;

    logic [uet_pkg::VTX_W-1:0]   r_key_lo, n_key_lo;
    logic [uet_pkg::VTX_W-1:0]   r_key_hi, n_key_hi;
    uet_pkg::t_link              r_head, n_head;
    uet_pkg::t_link              r_count, n_count;
    uet_pkg::t_link              r_listed, n_listed;
    logic [uet_pkg::HEAD_AW-1:0] r_vtx, n_vtx;

    logic                        r_valid, n_valid;
    logic [uet_pkg::STAT_W-1:0]  r_status, n_status;
    logic [uet_pkg::VTX_W-1:0]   r_out_lo, n_out_lo;
    logic [uet_pkg::VTX_W-1:0]   r_out_hi, n_out_hi;
    logic                        r_last, n_last;

    uet_pkg::t_store_req req;
    uet_pkg::t_store_rsp rsp;

    uet_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // next state, memory requests and result
    always_comb begin
        logic [uet_pkg::VTX_W-1:0]   lo;
        logic [uet_pkg::VTX_W-1:0]   hi;
        logic                        do_finish;
        uet_pkg::t_link              finish_link;
        uet_pkg::t_link              link_m1;
        logic [uet_pkg::HEAD_AW-1:0] vtx_inc;
        logic                        final_edge;

        lo          = (i_vertex_a < i_vertex_b) ? i_vertex_a : i_vertex_b;
        hi          = (i_vertex_a < i_vertex_b) ? i_vertex_b : i_vertex_a;
        do_finish   = 1'b0;
        finish_link = '0;
        link_m1     = '0;
        vtx_inc     = r_vtx + uet_pkg::HEAD_AW'(1);
        final_edge  = (r_listed + uet_pkg::LINK_W'(1)) == r_count;

        n_state  = r_state;
        n_key_lo = r_key_lo;
        n_key_hi = r_key_hi;
        n_head   = r_head;
        n_count  = r_count;
        n_listed = r_listed;
        n_vtx    = r_vtx;
        n_valid  = 1'b0;
        n_status = r_status;
        n_out_lo = r_out_lo;
        n_out_hi = r_out_hi;
        n_last   = r_last;
        req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == uet_pkg::CMD_INSERT) begin
                        n_key_lo       = lo;
                        n_key_hi       = hi;
                        req.head_rd    = 1'b1;
                        req.head_raddr = lo;
                        n_state        = S_INS_HEAD;
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = uet_pkg::ST_EMPTY;
                        n_out_lo = '0;
                        n_out_hi = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_vtx          = '0;
                        n_listed       = '0;
                        req.head_rd    = 1'b1;
                        req.head_raddr = '0;
                        n_state        = S_DUMP_HEAD;
                    end
                end
            end

            // head of the low vertex chain is available
            S_INS_HEAD: begin
                if (rsp.head_link == '0) begin
                    do_finish   = 1'b1;
                    finish_link = '0;
                end else begin
                    link_m1        = rsp.head_link - uet_pkg::LINK_W'(1);
                    n_head         = rsp.head_link;
                    req.node_rd    = 1'b1;
                    req.node_raddr = link_m1[uet_pkg::NODE_AW-1:0];
                    n_state        = S_INS_NODE;
                end
            end

            // compare one chain node per cycle
            S_INS_NODE: begin
                if (rsp.node.hi == r_key_hi) begin
                    n_valid  = 1'b1;
                    n_status = uet_pkg::ST_DUPLICATE;
                    n_out_lo = r_key_lo;
                    n_out_hi = r_key_hi;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else if (rsp.node.link == '0) begin
                    do_finish   = 1'b1;
                    finish_link = r_head;
                end else begin
                    link_m1        = rsp.node.link - uet_pkg::LINK_W'(1);
                    req.node_rd    = 1'b1;
                    req.node_raddr = link_m1[uet_pkg::NODE_AW-1:0];
                end
            end

            // head of the current vertex during a dump
            S_DUMP_HEAD: begin
                if (rsp.head_link == '0) begin
                    n_vtx          = vtx_inc;
                    req.head_rd    = 1'b1;
                    req.head_raddr = vtx_inc;
                end else begin
                    link_m1        = rsp.head_link - uet_pkg::LINK_W'(1);
                    req.node_rd    = 1'b1;
                    req.node_raddr = link_m1[uet_pkg::NODE_AW-1:0];
                    n_state        = S_DUMP_NODE;
                end
            end

            // list one node, then follow its link or move to the next vertex
            S_DUMP_NODE: begin
                n_valid  = 1'b1;
                n_status = uet_pkg::ST_LISTED;
                n_out_lo = r_vtx;
                n_out_hi = rsp.node.hi;
                n_last   = final_edge;
                n_listed = r_listed + uet_pkg::LINK_W'(1);
                if (final_edge) begin
                    n_state = S_IDLE;
                end else if (rsp.node.link != '0) begin
                    link_m1        = rsp.node.link - uet_pkg::LINK_W'(1);
                    req.node_rd    = 1'b1;
                    req.node_raddr = link_m1[uet_pkg::NODE_AW-1:0];
                end else begin
                    n_vtx          = vtx_inc;
                    req.head_rd    = 1'b1;
                    req.head_raddr = vtx_inc;
                    n_state        = S_DUMP_HEAD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of an insert walk without a match: push a new node unless the pool is full
        if (do_finish) begin
            n_valid  = 1'b1;
            n_out_lo = r_key_lo;
            n_out_hi = r_key_hi;
            n_last   = 1'b1;
            n_state  = S_IDLE;
            if (r_count == uet_pkg::LINK_W'(uet_pkg::MAX_EDGES)) begin
                n_status = uet_pkg::ST_FULL;
            end else begin
                n_status            = uet_pkg::ST_INSERTED;
                req.node_wr         = 1'b1;
                req.node_waddr      = r_count[uet_pkg::NODE_AW-1:0];
                req.node_wdata.hi   = r_key_hi;
                req.node_wdata.link = finish_link;
                req.head_wr         = 1'b1;
                req.head_waddr      = r_key_lo;
                req.head_wdata      = r_count + uet_pkg::LINK_W'(1);
                n_count             = r_count + uet_pkg::LINK_W'(1);
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_listed <= '0;
            r_vtx    <= '0;
            r_valid  <= 1'b0;
            r_status <= '0;
            r_out_lo <= '0;
            r_out_hi <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_listed <= n_listed;
            r_vtx    <= n_vtx;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_out_lo <= n_out_lo;
            r_out_hi <= n_out_hi;
            r_last   <= n_last;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_key_lo <= n_key_lo;
        r_key_hi <= n_key_hi;
        r_head   <= n_head;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_edge_low  = r_out_lo;
    assign o_edge_high = r_out_hi;
    assign o_last      = r_last;

endmodule

>>> hdl/uet_store.sv
// ----------------------------------------------------------------------------
// uet_store
// Chain head memory with per-entry valid bits and the edge node pool memory.
// Both reads are registered; a head never written reads as null.
// ----------------------------------------------------------------------------
module uet_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uet_pkg::t_store_req i_req,
    output uet_pkg::t_store_rsp o_rsp
);

    uet_pkg::t_link r_head_mem [uet_pkg::MAX_VERTICES];
    uet_pkg::t_node r_node_mem [uet_pkg::MAX_EDGES];

    logic [uet_pkg::MAX_VERTICES-1:0] r_head_valid;
    uet_pkg::t_link                   r_head_q;
    logic                             r_head_valid_q;
    uet_pkg::t_node                   r_node_q;

    // head valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
        end else if (i_req.head_wr) begin
            r_head_valid[i_req.head_waddr] <= 1'b1;
        end
    end

    // head memory
    always_ff @(posedge i_clk) begin
        if (i_req.head_wr) begin
            r_head_mem[i_req.head_waddr] <= i_req.head_wdata;
        end
        if (i_req.head_rd) begin
            r_head_q       <= r_head_mem[i_req.head_raddr];
            r_head_valid_q <= r_head_valid[i_req.head_raddr];
        end
    end

    // node pool memory
    always_ff @(posedge i_clk) begin
        if (i_req.node_wr) begin
            r_node_mem[i_req.node_waddr] <= i_req.node_wdata;
        end
        if (i_req.node_rd) begin
            r_node_q <= r_node_mem[i_req.node_raddr];
        end
    end

    // unwritten heads read as an empty chain
    assign o_rsp.head_link = r_head_valid_q ? r_head_q : '0;
    assign o_rsp.node      = r_node_q;

endmodule
